### design/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared widths, field types, input codes and inter-module structs.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Number of sensor channels and width of the microsecond counter.
  localparam int unsigned CHANNELS  = 5;
  localparam int unsigned TIME_BITS = 24;

  // Fixed field widths of the request and result payloads.
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned WIDTH_W = 24;
  localparam int unsigned DIST_W  = 32;

  // Half the speed of sound: micrometres of range per microsecond of echo.
  localparam int unsigned SPEED_UM_PER_US = 170;

  // Address width of the rise time memory.
  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [DIST_W-1:0]    dist_t;

  // Request mode and echo level codes.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EDGE  = 1'b1;
  localparam logic LEVEL_RISE = 1'b1;
  localparam logic LEVEL_FALL = 1'b0;

  // Access to the rise time memory.
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    addr_t addr;
    time_t wdata;
  } mem_req_t;

  // A falling edge on its way to the width calculation.
  typedef struct packed {
    logic  valid;
    chan_t chan;
    time_t now;
  } fall_t;

endpackage

### design/uer_in_if.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger request channel
// Valid/ready channel carrying ticks and echo edge events.
// ----------------------------------------------------------------------------
interface uer_in_if;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  uer_pkg::chan_t       channel;
  logic                 level;

  modport source (output valid, output mode, output channel, output level, input ready);
  modport sink   (input valid, input mode, input channel, input level, output ready);

endinterface

### design/uer_out_if.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger result channel
// Valid/ready channel carrying one finished echo measurement.
// ----------------------------------------------------------------------------
interface uer_out_if;

  logic            valid;
  logic            ready;
  uer_pkg::chan_t  sensor;
  uer_pkg::width_t width_us;
  uer_pkg::dist_t  distance_um;

  modport source (output valid, output sensor, output width_us, output distance_um,
                  input ready);
  modport sink   (input valid, input sensor, input width_us, input distance_um,
                  output ready);

endinterface

### design/uer_rise_mem.sv
// ----------------------------------------------------------------------------
// Rise time memory
// One entry per channel with a synchronous, registered read. Valid
// bits make an entry that was never written read as zero.
// ----------------------------------------------------------------------------
module uer_rise_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uer_pkg::mem_req_t req_i,
  output uer_pkg::time_t    rdata_o
);

  uer_pkg::time_t                mem [uer_pkg::CHANNELS];
  logic [uer_pkg::CHANNELS-1:0]  valid_q;
  uer_pkg::time_t                rdata_q;
  logic                          rvalid_q;

  // Storage array: write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // Entry valid bits, cleared by reset and set on the first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.addr];
      end
    end
  end

  // An unwritten entry reads as its reset value of zero.
  assign rdata_o = rvalid_q ? rdata_q : '0;

`ifndef SYNTHESIS
  // A request either stores a rise time or looks one up, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.wr_en && req_i.rd_en))
    else $error("rise memory read and write in the same cycle");

  // A written entry is valid from the next cycle on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |=> valid_q[$past(req_i.addr)])
    else $error("written entry not marked valid");

  // The read qualifier follows the valid bit of the address that was read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd_en |=> rvalid_q == $past(valid_q[req_i.addr]))
    else $error("read qualifier does not match entry valid bit");
`endif

endmodule

### design/uer_range_calc.sv
// ----------------------------------------------------------------------------
// Echo range calculation
// Subtracts the stored rise time from the fall time, then scales the width
// to micrometres in the output register.
// ----------------------------------------------------------------------------
module uer_range_calc (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  uer_pkg::fall_t  fall_i,
  input  uer_pkg::time_t  rise_i,
  output logic            valid_o,
  output uer_pkg::chan_t  sensor_o,
  output uer_pkg::width_t width_o,
  output uer_pkg::dist_t  dist_o
);

  logic            width_valid_q;
  uer_pkg::chan_t  width_chan_q;
  uer_pkg::width_t width_q;
  uer_pkg::time_t  diff;

  logic            out_valid_q;
  uer_pkg::chan_t  out_sensor_q;
  uer_pkg::width_t out_width_q;
  uer_pkg::dist_t  out_dist_q;

  // Modular pulse width; a wide counter reports its low bits.
  assign diff = fall_i.now - rise_i;

  // Stage valid flags advance together with the pipeline enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (en_i) begin
      width_valid_q <= fall_i.valid;
      out_valid_q   <= width_valid_q;
    end
  end

  // Payload registers: width stage, then the scaled result.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      width_chan_q <= fall_i.chan;
      width_q      <= uer_pkg::width_t'(diff);
      out_sensor_q <= width_chan_q;
      out_width_q  <= width_q;
      out_dist_q   <= uer_pkg::dist_t'(uer_pkg::dist_t'(width_q) *
                                       uer_pkg::dist_t'(uer_pkg::SPEED_UM_PER_US));
    end
  end

  assign valid_o  = out_valid_q;
  assign sensor_o = out_sensor_q;
  assign width_o  = out_width_q;
  assign dist_o   = out_dist_q;

endmodule

### design/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Multi-channel echo pulse timer: ticks advance a microsecond counter, rising
// edges store it per channel, falling edges report width and distance.
// ----------------------------------------------------------------------------
// A falling edge's result is built by the memory read at the accepting edge,
// then the width subtract, then the distance multiply into the output
// register. Throughput: one request per cycle; the pipeline stalls only
// while a result waits in the output register and ready is low.
// Reset clears the time counter, the per-channel valid bits of the rise time
// memory and all stage valid flags at once; no clearing pass is needed.
module ultrasonic_echo_ranger_core (
  input  logic clk_i,
  input  logic rst_ni,
  uer_in_if.sink    in_i,
  uer_out_if.source out_o
);

  logic              en;
  logic              in_fire;
  logic              is_edge;
  logic              in_range;
  uer_pkg::time_t    time_now_q;
  uer_pkg::mem_req_t mem_req;
  uer_pkg::time_t    rise_time;
  uer_pkg::fall_t    fall_d;
  uer_pkg::fall_t    fall_q;
  logic              out_valid;

  // Pipeline advances unless a result is held by the sink.
  assign en         = !out_valid || out_o.ready;
  assign in_i.ready = en;
  assign in_fire    = in_i.valid && en;

  // Request decode.
  assign is_edge  = in_fire && (in_i.mode == uer_pkg::MODE_EDGE);
  assign in_range = 32'(in_i.channel) < uer_pkg::CHANNELS;

  // Microsecond counter, advanced by each accepted tick and wrapping at its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
    end else if (in_fire && (in_i.mode == uer_pkg::MODE_TICK)) begin
      time_now_q <= time_now_q + uer_pkg::time_t'(1);
    end
  end

  // Rising edges store the time, falling edges look it up.
  always_comb begin
    mem_req.wr_en = is_edge && in_range && (in_i.level == uer_pkg::LEVEL_RISE);
    mem_req.rd_en = is_edge && in_range && (in_i.level == uer_pkg::LEVEL_FALL);
    mem_req.addr  = uer_pkg::addr_t'(in_i.channel);
    mem_req.wdata = time_now_q;
  end

  uer_rise_mem u_rise_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rise_time)
  );

  // Falling edge context travels alongside the memory read.
  always_comb begin
    fall_d.valid = mem_req.rd_en;
    fall_d.chan  = in_i.channel;
    fall_d.now   = time_now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_q <= '0;
    end else if (en) begin
      fall_q <= fall_d;
    end
  end

  uer_range_calc u_range_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .fall_i   (fall_q),
    .rise_i   (rise_time),
    .valid_o  (out_valid),
    .sensor_o (out_o.sensor),
    .width_o  (out_o.width_us),
    .dist_o   (out_o.distance_um)
  );

  assign out_o.valid = out_valid;

`ifndef SYNTHESIS
  // A tick moves the counter on by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.mode == uer_pkg::MODE_TICK) |=>
      time_now_q == uer_pkg::time_t'($past(time_now_q) + uer_pkg::time_t'(1)))
    else $error("time counter did not advance on a tick");

  // An accepted in-range falling edge enters the calculation stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.rd_en |=> fall_q.valid && fall_q.chan == $past(in_i.channel))
    else $error("falling edge lost before the width stage");

  // A delivered distance is always the reported width scaled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_o.distance_um == uer_pkg::dist_t'(uer_pkg::dist_t'(out_o.width_us) *
                                       uer_pkg::dist_t'(uer_pkg::SPEED_UM_PER_US)))
    else $error("distance does not match width");
`endif

endmodule

### test/ultrasonic_echo_ranger_core_test.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core testbench
// Sends ticks and echo edges through the request channel, predicts every
// echo measurement from a local model of the time counter and the per-channel
// rise times, and compares each result field by field. Both channels idle in
// random bursts, and the receiver once holds off long enough to stall input.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous cycle limit for the whole run.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REQUEST_COUNT = 600;
  localparam int unsigned QUIET_TAIL    = 80;
  localparam int unsigned HOLD_AFTER    = 150;
  localparam int unsigned HOLD_CYCLES   = 60;

  // One request on the input channel.
  typedef struct {
    logic           mode;
    uer_pkg::chan_t channel;
    logic           level;
  } echo_req_t;

  // One finished echo measurement.
  typedef struct {
    uer_pkg::chan_t  sensor;
    uer_pkg::width_t width_us;
    uer_pkg::dist_t  distance_um;
  } echo_meas_t;

  // Tracks the counter and rise times and holds the measurements still due.
  class echo_scoreboard;
    uer_pkg::time_t clock_us = '0;
    uer_pkg::time_t rise_at [uer_pkg::CHANNELS] = '{default: '0};
    echo_meas_t     due_q [$];
    int             fails = 0;

    function int pending();
      return due_q.size();
    endfunction

    // Applies one accepted request and queues the measurement it causes.
    function void note_request(logic mode, uer_pkg::chan_t chan, logic level);
      uer_pkg::time_t span;
      logic [63:0]    product;
      echo_meas_t     meas;
      if (mode == uer_pkg::MODE_TICK) begin
        clock_us = clock_us + uer_pkg::time_t'(1);
        return;
      end
      // Edges on channels that do not exist leave everything untouched.
      if (chan >= uer_pkg::CHANNELS) return;
      if (level == uer_pkg::LEVEL_RISE) begin
        rise_at[chan] = clock_us;
        return;
      end
      span             = clock_us - rise_at[chan];
      meas.sensor      = chan;
      meas.width_us    = uer_pkg::width_t'(span);
      product          = 64'(meas.width_us) * 64'(uer_pkg::SPEED_UM_PER_US);
      meas.distance_um = product[uer_pkg::DIST_W-1:0];
      due_q.push_back(meas);
    endfunction

    // Compares one accepted result with the oldest measurement due.
    function void check_result(uer_pkg::chan_t sensor, uer_pkg::width_t width_us,
                               uer_pkg::dist_t distance_um);
      echo_meas_t meas;
      if (due_q.size() == 0) begin
        $error("unexpected result: sensor %0d width_us %0d distance_um %0d",
               sensor, width_us, distance_um);
        fails++;
        return;
      end
      meas = due_q.pop_front();
      if (sensor !== meas.sensor) begin
        $error("sensor: expected %0d, actual %0d", meas.sensor, sensor);
        fails++;
      end
      if (width_us !== meas.width_us) begin
        $error("width_us: expected %0d, actual %0d", meas.width_us, width_us);
        fails++;
      end
      if (distance_um !== meas.distance_um) begin
        $error("distance_um: expected %0d, actual %0d", meas.distance_um, distance_um);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  uer_in_if  req_if ();
  uer_out_if res_if ();

  ultrasonic_echo_ranger_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  echo_scoreboard sb = new;
  echo_req_t      req_q [$];
  int unsigned    sent_count  = 0;
  int unsigned    cycle_count = 0;
  bit             quiet_phase = 1'b0;
  bit             hold_active = 1'b0;

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ultrasonic_echo_ranger_core: mismatch");
      $finish;
    end
  end

  // Both channels are sampled mid-cycle, when everything driven at the
  // rising edge has settled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.mode, req_if.channel, req_if.level);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.sensor, res_if.width_us, res_if.distance_um);
    end
  end

  function automatic void push_req(logic mode, uer_pkg::chan_t chan, logic level);
    echo_req_t r;
    r.mode    = mode;
    r.channel = chan;
    r.level   = level;
    req_q.push_back(r);
  endfunction

  // Directed opening, then mostly well-formed rise, ticks, fall sequences.
  function automatic void plan_requests();
    int             kind;
    int             ticks;
    uer_pkg::chan_t chan;
    // Falling edges straight after reset measure from a zero rise time.
    push_req(uer_pkg::MODE_EDGE, 3'd0, uer_pkg::LEVEL_FALL);
    push_req(uer_pkg::MODE_EDGE, 3'd4, uer_pkg::LEVEL_FALL);
    push_req(uer_pkg::MODE_TICK, 3'd7, 1'b1);
    push_req(uer_pkg::MODE_TICK, 3'd0, 1'b0);
    push_req(uer_pkg::MODE_TICK, 3'd5, 1'b1);
    // Repeated rising edges: the last one wins.
    push_req(uer_pkg::MODE_EDGE, 3'd1, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_TICK, 3'd2, 1'b0);
    push_req(uer_pkg::MODE_TICK, 3'd1, 1'b1);
    push_req(uer_pkg::MODE_EDGE, 3'd1, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_TICK, 3'd6, 1'b0);
    push_req(uer_pkg::MODE_EDGE, 3'd1, uer_pkg::LEVEL_FALL);
    // A second fall reuses the same rise time.
    push_req(uer_pkg::MODE_EDGE, 3'd1, uer_pkg::LEVEL_FALL);
    // Channels past the last one are ignored.
    push_req(uer_pkg::MODE_EDGE, 3'd5, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_EDGE, 3'd7, uer_pkg::LEVEL_FALL);
    push_req(uer_pkg::MODE_EDGE, 3'd6, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_EDGE, 3'd2, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_TICK, 3'd3, 1'b0);
    push_req(uer_pkg::MODE_EDGE, 3'd2, uer_pkg::LEVEL_FALL);
    push_req(uer_pkg::MODE_EDGE, 3'd3, uer_pkg::LEVEL_FALL);
    push_req(uer_pkg::MODE_EDGE, 3'd4, uer_pkg::LEVEL_RISE);
    push_req(uer_pkg::MODE_EDGE, 3'd4, uer_pkg::LEVEL_FALL);

    while (req_q.size() < REQUEST_COUNT) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        chan = uer_pkg::chan_t'($urandom_range(0, uer_pkg::CHANNELS - 1));
        push_req(uer_pkg::MODE_EDGE, chan, uer_pkg::LEVEL_RISE);
        if ($urandom_range(0, 15) == 0)
          ticks = $urandom_range(100, 300);
        else
          ticks = $urandom_range(0, 12);
        repeat (ticks) begin
          // An occasional edge on a random channel lands inside the pulse.
          if ($urandom_range(0, 7) == 0)
            push_req(uer_pkg::MODE_EDGE, uer_pkg::chan_t'($urandom_range(0, 7)),
                     logic'($urandom_range(0, 1)));
          push_req(uer_pkg::MODE_TICK, uer_pkg::chan_t'($urandom_range(0, 7)),
                   logic'($urandom_range(0, 1)));
        end
        push_req(uer_pkg::MODE_EDGE, chan, uer_pkg::LEVEL_FALL);
      end else begin
        push_req(logic'($urandom_range(0, 1)), uer_pkg::chan_t'($urandom_range(0, 7)),
                 logic'($urandom_range(0, 1)));
      end
    end
  endfunction

  // Request sender; also owns reset and the end of the run.
  initial begin
    int unsigned idx;
    int unsigned gap;
    bit          fire;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.mode    <= uer_pkg::MODE_TICK;
    req_if.channel <= '0;
    req_if.level   <= uer_pkg::LEVEL_FALL;
    plan_requests();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < req_q.size(); idx++) begin
      quiet_phase = (idx + QUIET_TAIL >= req_q.size());
      if (!quiet_phase && !hold_active && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      req_if.valid   <= 1'b1;
      req_if.mode    <= req_q[idx].mode;
      req_if.channel <= req_q[idx].channel;
      req_if.level   <= req_q[idx].level;
      do begin
        @(negedge clk_i);
        fire = req_if.valid && req_if.ready;
        @(posedge clk_i);
      end while (!fire);
      sent_count++;
    end
    req_if.valid <= 1'b0;

    // Drain the pipeline, then give it a few more cycles.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0)
      $display("ultrasonic_echo_ranger_core: match");
    else
      $display("ultrasonic_echo_ranger_core: mismatch");
    $finish;
  end

  // Result receiver: random ready bursts and one long hold-off.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    res_if.ready <= 1'b1;
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        hold_active = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (quiet_phase || $urandom_range(0, 2) != 0) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

endmodule
